// File: hdl/hse_pkg.sv
// hold/sustain envelope stage package: mode codes and the control bundle
// shared by the stage core and the top level; no dependencies
package hse_pkg;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_IDLE       = 3'd0;
    localparam t_mode MODE_DEFERRING  = 3'd1;
    localparam t_mode MODE_TRACKING   = 3'd2;
    localparam t_mode MODE_HOLDING    = 3'd3;
    localparam t_mode MODE_SUSTAINING = 3'd4;

    typedef struct packed {
        logic defer;
        logic sustain_mode;
        logic gate;
    } t_ctl;

endpackage

// File: hdl/hold_sustain_envelope_stage.sv
// hold/sustain envelope stage top level: input register, stage core,
// result register and the end-of-cycle step register
// depends on hse_pkg and hse_core
//
// One result item per input item, one item per clock when the output is not
// stalled. An item is captured in the input register, the state update in
// the core runs on it, and its result lands in the result register, which
// drives o_valid. The input stalls only while both registers are full and
// the output is stalled. The end-of-cycle step is a Q fraction written
// through i_cfg_we and i_cfg_data; it comes out of reset as sample period
// over 1 ms at 46 kHz.
module hold_sustain_envelope_stage #(
    parameter int SAMPLE_BITS         = 16,
    parameter int PHASE_FRACTION_BITS = 24,
    parameter int EOC_STEP_RESET      = 364722
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_defer,
    input  logic                                i_sustain_mode,
    input  logic                                i_gate,
    input  logic signed [SAMPLE_BITS-1:0]       i_envelope_in,
    input  logic [PHASE_FRACTION_BITS:0]        i_hold_step,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_envelope_out,
    output logic                                o_active,
    output logic                                o_eoc,
    input  logic                                i_cfg_we,
    input  logic [PHASE_FRACTION_BITS:0]        i_cfg_data
);
    import hse_pkg::*;

    localparam int PW = PHASE_FRACTION_BITS + 1;

    logic [PW-1:0]                  r_eoc_step;
    logic                           r_in_valid;
    t_ctl                           r_in_ctl;
    logic signed [SAMPLE_BITS-1:0]  r_in_level;
    logic [PW-1:0]                  r_in_hold_step;
    logic                           r_out_valid;
    logic signed [SAMPLE_BITS-1:0]  r_out_level;
    logic                           r_out_active;
    logic                           r_out_eoc;

    logic                           out_free;
    logic                           in_take;
    logic                           core_en;
    logic signed [SAMPLE_BITS-1:0]  core_level;
    logic                           core_active;
    logic                           core_eoc;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;
    assign core_en  = r_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eoc_step <= PW'(EOC_STEP_RESET);
        end else if (i_cfg_we) begin
            r_eoc_step <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (core_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ctl       <= '{defer: i_defer, sustain_mode: i_sustain_mode,
                                gate: i_gate};
            r_in_level     <= i_envelope_in;
            r_in_hold_step <= i_hold_step;
        end
    end

    hse_core #(
        .SAMPLE_BITS         (SAMPLE_BITS),
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (core_en),
        .i_ctl       (r_in_ctl),
        .i_level     (r_in_level),
        .i_hold_step (r_in_hold_step),
        .i_eoc_step  (r_eoc_step),
        .o_level     (core_level),
        .o_active    (core_active),
        .o_eoc       (core_eoc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_en) begin
            r_out_level  <= core_level;
            r_out_active <= core_active;
            r_out_eoc    <= core_eoc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_envelope_out = r_out_level;
    assign o_active       = r_out_active;
    assign o_eoc          = r_out_eoc;

endmodule

// File: hdl/hse_core.sv
// hold/sustain envelope stage core: mode, held level and the two Q phases,
// updated once per enabled cycle; the result comes out combinationally
// depends on hse_pkg
module hse_core #(
    parameter int SAMPLE_BITS         = 16,
    parameter int PHASE_FRACTION_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  hse_pkg::t_ctl                       i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]       i_level,
    input  logic [PHASE_FRACTION_BITS:0]        i_hold_step,
    input  logic [PHASE_FRACTION_BITS:0]        i_eoc_step,
    output logic signed [SAMPLE_BITS-1:0]       o_level,
    output logic                                o_active,
    output logic                                o_eoc
);
    import hse_pkg::*;

    localparam int PW = PHASE_FRACTION_BITS + 1;
    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << PHASE_FRACTION_BITS;

    t_mode                          r_mode, n_mode;
    logic                           r_gate_was_high, n_gate_was_high;
    logic signed [SAMPLE_BITS-1:0]  r_held_level, n_held_level;
    logic [PW-1:0]                  r_hold_phase, n_hold_phase;
    logic                           r_eoc_flag, n_eoc_flag;
    logic [PW-1:0]                  r_eoc_phase, n_eoc_phase;

    t_mode                          mode_sel;
    logic [PW:0]                    hold_sum;
    logic [PW:0]                    eoc_sum;

    always_comb begin
        n_mode          = r_mode;
        n_gate_was_high = r_gate_was_high;
        n_held_level    = r_held_level;
        n_hold_phase    = r_hold_phase;
        n_eoc_flag      = r_eoc_flag;
        n_eoc_phase     = r_eoc_phase;
        hold_sum        = '0;
        eoc_sum         = '0;
        o_level         = r_held_level;

        // mode selection, defer first
        if (i_ctl.defer) begin
            mode_sel = MODE_DEFERRING;
        end else if (i_ctl.sustain_mode && i_ctl.gate) begin
            mode_sel = MODE_SUSTAINING;
        end else if (i_ctl.sustain_mode && r_mode == MODE_SUSTAINING) begin
            mode_sel = MODE_IDLE;
        end else if (r_mode == MODE_DEFERRING) begin
            mode_sel = MODE_TRACKING;
        end else begin
            n_gate_was_high = i_ctl.gate;
            if (i_ctl.gate && !r_gate_was_high) begin
                n_held_level = i_level;
                n_hold_phase = '0;
                n_mode       = MODE_HOLDING;
            end
            mode_sel = n_mode;
        end

        if (mode_sel != n_mode) begin
            if (n_mode == MODE_DEFERRING) begin
                n_gate_was_high = 1'b0;
            end
            if (mode_sel == MODE_HOLDING || mode_sel == MODE_SUSTAINING) begin
                n_held_level = i_level;
                n_hold_phase = '0;
            end
            if (mode_sel == MODE_IDLE) begin
                n_eoc_flag  = 1'b1;
                n_eoc_phase = '0;
            end
            n_mode = mode_sel;
        end

        // hold phase and output level
        if (n_mode == MODE_DEFERRING || n_mode == MODE_TRACKING) begin
            o_level = i_level;
        end else begin
            if (n_mode == MODE_HOLDING && n_hold_phase < PHASE_ONE) begin
                hold_sum     = {1'b0, n_hold_phase} + {1'b0, i_hold_step};
                n_hold_phase = (hold_sum > {1'b0, PHASE_ONE}) ? PHASE_ONE
                                                              : hold_sum[PW-1:0];
                if (n_hold_phase == PHASE_ONE) begin
                    n_eoc_flag  = 1'b1;
                    n_eoc_phase = '0;
                    n_mode      = MODE_IDLE;
                end
            end
            o_level = n_held_level;
        end

        // end-of-cycle pulse
        if (n_eoc_phase < PHASE_ONE) begin
            eoc_sum     = {1'b0, n_eoc_phase} + {1'b0, i_eoc_step};
            n_eoc_phase = (eoc_sum > {1'b0, PHASE_ONE}) ? PHASE_ONE
                                                        : eoc_sum[PW-1:0];
            if (n_eoc_phase == PHASE_ONE) begin
                n_eoc_flag = 1'b0;
            end
        end

        o_active = (n_mode != MODE_IDLE) && (n_mode != MODE_TRACKING);
        o_eoc    = n_eoc_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_gate_was_high <= 1'b0;
            r_held_level    <= '0;
            r_hold_phase    <= '0;
            r_eoc_flag      <= 1'b0;
            r_eoc_phase     <= PHASE_ONE;
        end else if (i_en) begin
            r_mode          <= n_mode;
            r_gate_was_high <= n_gate_was_high;
            r_held_level    <= n_held_level;
            r_hold_phase    <= n_hold_phase;
            r_eoc_flag      <= n_eoc_flag;
            r_eoc_phase     <= n_eoc_phase;
        end
    end

endmodule

// File: hdl/hse_port_checker.sv
// hold/sustain envelope stage port checker and its bind to the top level
// depends on hold_sustain_envelope_stage
module hse_port_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_envelope_out,
    input logic                          o_active,
    input logic                          o_eoc
);

    // result register empties on reset
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item present after reset");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result item dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            ($stable(o_envelope_out) && $stable(o_active) && $stable(o_eoc)))
        else $error("result item changed while stalled");

endmodule

bind hold_sustain_envelope_stage hse_port_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_port_checker (.*);
